[src/assert_macros.svh]
// Assertion macros used by the key event FIFO RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/kef_pkg.sv]
// Types and constants for the key event FIFO peripheral.
package kef_pkg;

    localparam int DATA_W = 64;
    localparam int VER_W  = 32;

    localparam logic [3:0] BUS_WIDTH_BYTES = 4'd8;
    localparam logic [1:0] BUS_BAR_OK      = 2'd0;

    // control register bits
    localparam int CTL_ENABLE = 0;
    localparam int CTL_IRQ_EN = 1;

    // irq status bits
    localparam int IRQ_EVENT    = 0;
    localparam int IRQ_OVERFLOW = 1;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        REG_CONTROL  = 3'd0,
        REG_STATUS   = 3'd1,
        REG_COUNT    = 3'd2,
        REG_EVENT    = 3'd3,
        REG_CAPACITY = 3'd4,
        REG_IRQ      = 3'd5,
        REG_DROPPED  = 3'd6,
        REG_VERSION  = 3'd7
    } t_reg_sel;

    typedef struct packed {
        logic push;
        logic pop;
    } t_chain_ctl;

endpackage

[src/kef_cell.sv]
// One storage cell of the event chain: loads a new event or takes its upper neighbor's.
module kef_cell (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic                       i_shift,
    input  logic [kef_pkg::DATA_W-1:0] i_wdata,
    input  logic [kef_pkg::DATA_W-1:0] i_upper,
    output logic [kef_pkg::DATA_W-1:0] o_data
);
    import kef_pkg::*;

    logic [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_upper;
        end else if (i_load) begin
            r_data <= i_wdata;
        end
    end

    assign o_data = r_data;

endmodule

[src/kef_chain.sv]
// Row of event cells; head is cell 0, pops shift every cell down by one.
module kef_chain #(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  kef_pkg::t_chain_ctl        i_ctl,
    input  logic [CNT_W-1:0]           i_count,
    input  logic [kef_pkg::DATA_W-1:0] i_wdata,
    output logic [kef_pkg::DATA_W-1:0] o_head
);
    import kef_pkg::*;

    logic [DATA_W-1:0] w_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] w_upper;
        logic              w_load;

        if (i == DEPTH - 1) begin : g_top
            assign w_upper = '0;
        end else begin : g_mid
            assign w_upper = w_data[i+1];
        end

        // new event lands in the first free cell
        assign w_load = i_ctl.push && (i_count == CNT_W'(i));

        kef_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (w_load),
            .i_shift (i_ctl.pop),
            .i_wdata (i_wdata),
            .i_upper (w_upper),
            .o_data  (w_data[i])
        );
    end

    assign o_head = w_data[0];

endmodule

[src/key_event_fifo_mmio.sv]
// Top level of the key event FIFO peripheral: register file, FIFO control, result register.
//
//  channel   signals                                   transfer at
//  --------  ----------------------------------------  ---------------------------
//  command   i_start, o_busy, i_opcode .. i_data_word  i_start && !o_busy
//  result    o_valid, o_read_data, o_access_ok, o_irq_pulse  o_valid (one cycle)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data      i_cfg_valid && o_cfg_ready
//
// Each command is handled combinationally; its registered result shows on the cycle after the transfer.
// o_busy stays low, so a command may be issued every cycle.
// Pops shift the cell row by one in that same cycle; pushes load the first free cell.
// Reset is synchronous; FIFO contents are not cleared, but fill count, control, flags, drop count and valid are.
// The result side cannot stall: o_valid lasts exactly one cycle.
`include "assert_macros.svh"

module key_event_fifo_mmio #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [1:0]                 i_opcode,
    input  logic [2:0]                 i_reg_select,
    input  logic [1:0]                 i_bus_bar,
    input  logic [3:0]                 i_access_width,
    input  logic [kef_pkg::DATA_W-1:0] i_data_word,
    output logic                       o_valid,
    output logic [kef_pkg::DATA_W-1:0] o_read_data,
    output logic                       o_access_ok,
    output logic                       o_irq_pulse,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [kef_pkg::VER_W-1:0]  i_cfg_data
);
    import kef_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]  r_fill_count, n_fill_count;
    logic [1:0]        r_ctl, n_ctl;
    logic              r_ovf, n_ovf;
    logic [1:0]        r_irq, n_irq;
    logic [DATA_W-1:0] r_drop, n_drop;
    logic [VER_W-1:0]  r_version;

    logic              r_valid;
    logic [DATA_W-1:0] r_rdata, n_rdata;
    logic              r_ok, n_ok;
    logic              r_raise, n_raise;

    t_chain_ctl        w_ctl;
    logic [DATA_W-1:0] w_head;
    logic              w_bus_good;
    logic              w_full;
    logic              w_empty;
    t_opcode           w_op;
    t_reg_sel          w_reg;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign w_op       = t_opcode'(i_opcode);
    assign w_reg      = t_reg_sel'(i_reg_select);
    assign w_bus_good = (i_bus_bar == BUS_BAR_OK) && (i_access_width == BUS_WIDTH_BYTES);
    assign w_full     = (r_fill_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty    = (r_fill_count == '0);

    kef_chain #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_count (r_fill_count),
        .i_wdata (i_data_word),
        .o_head  (w_head)
    );

    always_comb begin
        n_fill_count = r_fill_count;
        n_ctl        = r_ctl;
        n_ovf        = r_ovf;
        n_irq        = r_irq;
        n_drop       = r_drop;
        n_rdata      = '0;
        n_ok         = 1'b0;
        n_raise      = 1'b0;
        w_ctl        = '0;

        if (i_start) begin
            unique case (w_op)
                OP_PUSH: begin
                    if (r_ctl[CTL_ENABLE]) begin
                        if (w_full) begin
                            n_drop                = r_drop + DATA_W'(1);
                            n_ovf                 = 1'b1;
                            n_irq[IRQ_OVERFLOW]   = 1'b1;
                        end else begin
                            w_ctl.push            = 1'b1;
                            n_fill_count          = r_fill_count + CNT_W'(1);
                            n_irq[IRQ_EVENT]      = 1'b1;
                        end
                        n_raise = r_ctl[CTL_IRQ_EN];
                    end
                end
                OP_READ: begin
                    if (w_bus_good) begin
                        n_ok = 1'b1;
                        unique case (w_reg)
                            REG_CONTROL:  n_rdata = DATA_W'(r_ctl);
                            REG_STATUS:   n_rdata = DATA_W'({!w_empty, r_ovf});
                            REG_COUNT:    n_rdata = DATA_W'(r_fill_count);
                            REG_EVENT: begin
                                if (!w_empty) begin
                                    n_rdata      = w_head;
                                    w_ctl.pop    = 1'b1;
                                    n_fill_count = r_fill_count - CNT_W'(1);
                                    if (r_fill_count == CNT_W'(1)) begin
                                        n_irq[IRQ_EVENT] = 1'b0;
                                    end
                                end
                            end
                            REG_CAPACITY: n_rdata = DATA_W'(QUEUE_DEPTH);
                            REG_IRQ:      n_rdata = DATA_W'(r_irq);
                            REG_DROPPED:  n_rdata = r_drop;
                            REG_VERSION:  n_rdata = DATA_W'(r_version);
                            default:      n_rdata = '0;
                        endcase
                    end
                end
                OP_WRITE: begin
                    if (w_bus_good) begin
                        unique case (w_reg)
                            REG_CONTROL: begin
                                n_ok  = 1'b1;
                                n_ctl = i_data_word[1:0];
                                if (!i_data_word[CTL_ENABLE]) begin
                                    // disable flushes the queue and all flags
                                    n_fill_count = '0;
                                    n_ovf        = 1'b0;
                                    n_irq        = '0;
                                end else begin
                                    n_raise = i_data_word[CTL_IRQ_EN] && (r_irq != '0);
                                end
                            end
                            REG_STATUS: begin
                                n_ok = 1'b1;
                                if (i_data_word[0]) begin
                                    n_ovf = 1'b0;
                                end
                            end
                            REG_IRQ: begin
                                n_ok  = 1'b1;
                                n_irq = r_irq & ~i_data_word[1:0];
                            end
                            REG_DROPPED: begin
                                n_ok = 1'b1;
                                if (i_data_word != '0) begin
                                    n_drop = '0;
                                end
                            end
                            default: n_ok = 1'b0;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_count <= '0;
            r_ctl        <= '0;
            r_ovf        <= 1'b0;
            r_irq        <= '0;
            r_drop       <= '0;
            r_version    <= VER_W'(1);
            r_valid      <= 1'b0;
        end else begin
            r_fill_count <= n_fill_count;
            r_ctl        <= n_ctl;
            r_ovf        <= n_ovf;
            r_irq        <= n_irq;
            r_drop       <= n_drop;
            r_valid      <= i_start;
            if (i_cfg_valid) begin
                r_version <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= n_rdata;
        r_ok    <= n_ok;
        r_raise <= n_raise;
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_rdata;
    assign o_access_ok = r_ok && r_valid;
    assign o_irq_pulse = r_raise && r_valid;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_fill_count <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_start && !o_busy, o_valid)
    `ASSERT_IMPLY(a_irq_needs_enable, i_clk, i_rst_n, o_irq_pulse, r_ctl[CTL_IRQ_EN])
    `ASSERT_NEXT(a_empty_pop_holds, i_clk, i_rst_n,
        i_start && w_op == OP_READ && w_reg == REG_EVENT && w_empty, r_fill_count == '0)
    `ASSERT_IMPLY(a_no_push_pop, i_clk, i_rst_n, w_ctl.push, !w_ctl.pop && !w_full)

endmodule
